@@ rtl/pnt_pkg.sv @@
package pnt_pkg;

   localparam int unsigned NUMBER_WIDTH = 16;
   localparam int unsigned SUM_WIDTH    = 20;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic accum;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;
      logic last_step;
   } dp_sts_type;

endpackage

@@ rtl/pnt_dp.sv @@
module pnt_dp #(
   parameter int unsigned NW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pnt_pkg::dp_cmd_type                 cmd,
   output pnt_pkg::dp_sts_type                 sts,
   input  logic [pnt_pkg::NUMBER_WIDTH-1:0]    number,
   output logic                                is_perfect,
   output logic [pnt_pkg::SUM_WIDTH-1:0]       divisor_sum
);

   localparam int unsigned CW = (NW > 1) ? $clog2(NW) : 1;
   localparam int unsigned SW = pnt_pkg::SUM_WIDTH;

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] div_ff, div_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] shf_ff, shf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW:0]   rem_sh;
   logic [NW:0]   rem_diff;

   // one restoring division step: bring down the next dividend bit
   assign rem_sh   = {rem_ff, shf_ff[NW-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      num_in = num_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      shf_in = shf_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (cmd.load) begin
         num_in = number[NW-1:0];
         div_in = NW'(1);
         sum_in = '0;
      end
      if (cmd.div_init) begin
         rem_in = '0;
         shf_in = num_ff;
         cnt_in = CW'(NW - 1);
      end
      if (cmd.div_step) begin
         shf_in = {shf_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_diff[NW-1:0];
         end else begin
            rem_in = rem_sh[NW-1:0];
         end
      end
      if (cmd.accum) begin
         if (rem_ff == '0) begin
            sum_in = sum_ff + SW'(div_ff);
         end
         div_in = div_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         div_ff <= '0;
         rem_ff <= '0;
         shf_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         num_ff <= num_in;
         div_ff <= div_in;
         rem_ff <= rem_in;
         shf_ff <= shf_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   assign sts.more      = (div_ff < num_ff);
   assign sts.last_step = (cnt_ff == '0);

   assign is_perfect  = (num_ff != '0) && (sum_ff == SW'(num_ff));
   assign divisor_sum = sum_ff;

endmodule

@@ rtl/pnt_ctrl.sv @@
module pnt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output pnt_pkg::dp_cmd_type  cmd,
   input  pnt_pkg::dp_sts_type  sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_ACCUM
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_CHECK;
                  busy_ff  <= 1'b1;
               end
            end
            ST_CHECK: begin
               if (sts.more) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  // every candidate tried, word goes out next cycle
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
                  valid_ff <= 1'b1;
               end
            end
            ST_DIVIDE: begin
               if (sts.last_step) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: begin
               state_ff <= ST_CHECK;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load     = (state_ff == ST_IDLE) && start;
      cmd.div_init = (state_ff == ST_CHECK) && sts.more;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.accum    = (state_ff == ST_ACCUM);
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

@@ rtl/perfect_number_test_core.sv @@
// Perfect number test. A word is taken on a clock edge with start high and busy low; the low
// min(NUM_WIDTH, 16) bits of req_number are used. Every candidate divisor d from 1 to n-1 is
// tried on a one-bit-per-cycle restoring divider, and each d that leaves no remainder is added
// to the sum. Each candidate goes through a compare, the division steps, one per dividend bit,
// and an accumulate. The result is on the rsp_ ports for exactly one cycle with rsp_valid high,
// and busy is low from that cycle on. The receiver cannot stall: rsp_valid is not held, so the
// word must be taken in that cycle or it is gone.
module perfect_number_test_core #(
   parameter int unsigned NUM_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pnt_pkg::NUMBER_WIDTH-1:0]    req_number,
   output logic                                rsp_valid,
   output logic                                rsp_is_perfect,
   output logic [pnt_pkg::SUM_WIDTH-1:0]       rsp_divisor_sum
);

   localparam int unsigned NW =
      (NUM_WIDTH < pnt_pkg::NUMBER_WIDTH) ? NUM_WIDTH : pnt_pkg::NUMBER_WIDTH;

   pnt_pkg::dp_cmd_type cmd;
   pnt_pkg::dp_sts_type sts;

   pnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   pnt_dp #(
      .NW (NW)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .number      (req_number),
      .is_perfect  (rsp_is_perfect),
      .divisor_sum (rsp_divisor_sum)
   );

endmodule
